[hw/rtl/md2_hash_engine_core_assert.svh]
// Assertion macros for the MD2 hash engine.
`ifndef MD2_HASH_ENGINE_CORE_ASSERT_SVH
`define MD2_HASH_ENGINE_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MD2_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("md2 assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define MD2_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("md2 assertion failed");

`endif

[hw/rtl/md2_pkg.sv]
// ----------------------------------------------------------------------------
// MD2 package
// Shared types, constants and the pi substitution table for the MD2 engine.
// ----------------------------------------------------------------------------
package md2_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int WORK_BYTES  = 48;
	localparam int ROUNDS      = 18;
	localparam int TDATA_IN_W  = 8;
	localparam int TUSER_IN_W  = 1;
	localparam int TDATA_OUT_W = 128;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_CSUM,
		ST_PAD,
		ST_OUT
	} md2_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       absorb;     // write in_byte to the buffer at fill
		logic       pad_byte;   // write pad value to the buffer at fill
		logic       load;       // form the 48-byte work block
		logic       final_blk;  // block source is the checksum
		logic       round_step; // one S-box step on the work block
		logic       csum_step;  // one checksum byte update
		logic       commit;     // copy work block into chaining state
		logic       clear;      // clear all state after the digest
	} md2_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       buf_full;   // fill count wrapped to 16
		logic       fill_zero;
		logic       round_last; // last step of the last round
		logic       csum_last;  // last checksum byte
	} md2_stat_t;

	function automatic logic [7:0] pi_sbox(input logic [7:0] idx);
		logic [7:0] tbl [256];
		tbl = '{
			8'd41, 8'd46, 8'd67, 8'd201, 8'd162, 8'd216, 8'd124, 8'd1, 8'd61, 8'd54,
			8'd84, 8'd161, 8'd236, 8'd240, 8'd6, 8'd19, 8'd98, 8'd167, 8'd5, 8'd243,
			8'd192, 8'd199, 8'd115, 8'd140, 8'd152, 8'd147, 8'd43, 8'd217, 8'd188,
			8'd76, 8'd130, 8'd202, 8'd30, 8'd155, 8'd87, 8'd60, 8'd253, 8'd212,
			8'd224, 8'd22, 8'd103, 8'd66, 8'd111, 8'd24, 8'd138, 8'd23, 8'd229,
			8'd18, 8'd190, 8'd78, 8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
			8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47, 8'd238, 8'd122, 8'd169,
			8'd104, 8'd121, 8'd145, 8'd21, 8'd178, 8'd7, 8'd63, 8'd148, 8'd194,
			8'd16, 8'd137, 8'd11, 8'd34, 8'd95, 8'd33, 8'd128, 8'd127, 8'd93,
			8'd154, 8'd90, 8'd144, 8'd50, 8'd39, 8'd53, 8'd62, 8'd204, 8'd231,
			8'd191, 8'd247, 8'd151, 8'd3, 8'd255, 8'd25, 8'd48, 8'd179, 8'd72,
			8'd165, 8'd181, 8'd209, 8'd215, 8'd94, 8'd146, 8'd42, 8'd172, 8'd86,
			8'd170, 8'd198, 8'd79, 8'd184, 8'd56, 8'd210, 8'd150, 8'd164, 8'd125,
			8'd182, 8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4, 8'd241,
			8'd69, 8'd157, 8'd112, 8'd89, 8'd100, 8'd113, 8'd135, 8'd32, 8'd134,
			8'd91, 8'd207, 8'd101, 8'd230, 8'd45, 8'd168, 8'd2, 8'd27, 8'd96,
			8'd37, 8'd173, 8'd174, 8'd176, 8'd185, 8'd246, 8'd28, 8'd70, 8'd97,
			8'd105, 8'd52, 8'd64, 8'd126, 8'd15, 8'd85, 8'd71, 8'd163, 8'd35,
			8'd221, 8'd81, 8'd175, 8'd58, 8'd195, 8'd92, 8'd249, 8'd206, 8'd186,
			8'd197, 8'd234, 8'd38, 8'd44, 8'd83, 8'd13, 8'd110, 8'd133, 8'd40,
			8'd132, 8'd9, 8'd211, 8'd223, 8'd205, 8'd244, 8'd65, 8'd129, 8'd77,
			8'd82, 8'd106, 8'd220, 8'd55, 8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
			8'd36, 8'd225, 8'd123, 8'd8, 8'd12, 8'd189, 8'd177, 8'd74, 8'd120,
			8'd136, 8'd149, 8'd139, 8'd227, 8'd99, 8'd232, 8'd109, 8'd233, 8'd203,
			8'd213, 8'd254, 8'd59, 8'd0, 8'd29, 8'd57, 8'd242, 8'd239, 8'd183,
			8'd14, 8'd102, 8'd88, 8'd208, 8'd228, 8'd166, 8'd119, 8'd114, 8'd248,
			8'd235, 8'd117, 8'd75, 8'd10, 8'd49, 8'd68, 8'd80, 8'd180, 8'd143,
			8'd237, 8'd31, 8'd26, 8'd219, 8'd153, 8'd141, 8'd51, 8'd159, 8'd17,
			8'd131, 8'd20
		};
		return tbl[idx];
	endfunction

endpackage

[hw/rtl/md2_ctrl.sv]
// ----------------------------------------------------------------------------
// MD2 controller
// Sequences absorb, compression, checksum, padding and digest output.
// ----------------------------------------------------------------------------
module md2_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_present,
	input  logic              in_end,
	input  logic              out_taken,
	input  md2_pkg::md2_stat_t stat,
	output md2_pkg::md2_cmd_t  cmd,
	output logic              in_ready,
	output logic              out_valid
);
	import md2_pkg::*;

	md2_state_t state_q, state_d;
	logic       end_pend_q;  // message end is pending
	logic       final_q;     // current compression is the checksum block
	// Set once padding has written at least one byte; then the next full
	// block is the last message block and the checksum follows it.
	logic       padded_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_present && stat.buf_full) state_d = ST_LOAD;
					else if (in_end) state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (stat.buf_full) state_d = ST_LOAD;
			end
			ST_LOAD: state_d = ST_ROUND;
			ST_ROUND: begin
				if (stat.round_last) state_d = final_q ? ST_OUT : ST_CSUM;
			end
			ST_CSUM: begin
				if (stat.csum_last) begin
					if (!end_pend_q) state_d = ST_IDLE;
					else if (stat.fill_zero && !final_q && padded_q) state_d = ST_LOAD;
					else state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (out_taken) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			end_pend_q <= 1'b0;
			final_q    <= 1'b0;
			padded_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_fire && in_end) end_pend_q <= 1'b1;
			if (state_q == ST_PAD) padded_q <= 1'b1;
			if (state_q == ST_CSUM && stat.csum_last && end_pend_q && padded_q)
				final_q <= 1'b1;
			if (state_q == ST_OUT && out_taken) begin
				end_pend_q <= 1'b0;
				final_q    <= 1'b0;
				padded_q   <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.absorb     = (state_q == ST_IDLE) && in_fire && in_present;
		cmd.pad_byte   = (state_q == ST_PAD);
		cmd.load       = (state_q == ST_LOAD);
		cmd.final_blk  = final_q;
		cmd.round_step = (state_q == ST_ROUND);
		cmd.csum_step  = (state_q == ST_CSUM);
		cmd.commit     = (state_q == ST_ROUND) && stat.round_last;
		cmd.clear      = (state_q == ST_OUT) && out_taken;
		in_ready       = (state_q == ST_IDLE);
		out_valid      = (state_q == ST_OUT);
	end

endmodule

[hw/rtl/md2_dp.sv]
// ----------------------------------------------------------------------------
// MD2 datapath
// Block buffer, 48-byte work block with one S-box step per cycle, checksum.
// ----------------------------------------------------------------------------
module md2_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  md2_pkg::md2_cmd_t  cmd,
	input  logic [7:0]        in_byte,
	output md2_pkg::md2_stat_t stat,
	output logic [127:0]      digest
);
	import md2_pkg::*;

	logic [7:0] buf_q  [BLOCK_BYTES];
	logic [7:0] work_q [WORK_BYTES];
	logic [7:0] chain_q [BLOCK_BYTES];
	logic [7:0] csum_q  [BLOCK_BYTES];
	logic [3:0] fill_q;
	logic [5:0] pos_q;    // work block position
	logic [4:0] rnd_q;    // round number
	logic [3:0] cpos_q;   // checksum position
	logic [7:0] t_q;      // running S-box index
	logic [7:0] ct_q;     // checksum carry byte
	logic [7:0] pad_q;    // pad value held for the rest of the padding run
	logic       pad_run_q;
	logic [7:0] pad_val;
	logic [7:0] blk_byte;
	logic [7:0] step_val;
	logic [7:0] csum_val;
	logic       wr_buf;

	// The pad value is fixed by the fill count at the first pad byte.
	assign pad_val  = pad_run_q ? pad_q : (8'd16 - {4'd0, fill_q});
	assign wr_buf   = cmd.absorb || cmd.pad_byte;
	// The work block rotates by one byte per step, so the byte being
	// updated is always at the head.
	assign step_val = work_q[0] ^ pi_sbox(t_q);
	assign blk_byte = buf_q[cpos_q];
	assign csum_val = csum_q[cpos_q] ^ pi_sbox(blk_byte ^ ct_q);

	assign stat.buf_full   = wr_buf && (fill_q == 4'hf);
	assign stat.fill_zero  = (fill_q == 4'd0);
	assign stat.round_last = (pos_q == 6'(WORK_BYTES - 1)) && (rnd_q == 5'(ROUNDS - 1));
	assign stat.csum_last  = (cpos_q == 4'hf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			pos_q     <= '0;
			rnd_q     <= '0;
			cpos_q    <= '0;
			t_q       <= '0;
			ct_q      <= '0;
			pad_q     <= '0;
			pad_run_q <= 1'b0;
			for (int i = 0; i < BLOCK_BYTES; i++) begin
				chain_q[i] <= '0;
				csum_q[i]  <= '0;
			end
		end else if (cmd.clear) begin
			fill_q <= '0;
			for (int i = 0; i < BLOCK_BYTES; i++) begin
				chain_q[i] <= '0;
				csum_q[i]  <= '0;
			end
		end else begin
			pad_run_q <= cmd.pad_byte;
			pad_q     <= pad_val;
			if (wr_buf) fill_q <= fill_q + 4'd1;
			if (cmd.load) begin
				pos_q  <= '0;
				rnd_q  <= '0;
				t_q    <= '0;
				cpos_q <= '0;
				ct_q   <= csum_q[BLOCK_BYTES-1];
			end
			if (cmd.round_step) begin
				t_q <= step_val;
				if (pos_q == 6'(WORK_BYTES - 1)) begin
					pos_q <= '0;
					rnd_q <= rnd_q + 5'd1;
					t_q   <= step_val + {3'd0, rnd_q};
				end else begin
					pos_q <= pos_q + 6'd1;
				end
			end
			// On the last step byte 0 of the work block sits one place behind the head.
			if (cmd.commit) begin
				for (int i = 0; i < BLOCK_BYTES; i++) chain_q[i] <= work_q[i + 1];
			end
			if (cmd.csum_step) begin
				csum_q[cpos_q] <= csum_val;
				ct_q           <= csum_val;
				cpos_q         <= cpos_q + 4'd1;
			end
		end
	end

	// Payload storage: the buffer and the work block need no reset.
	always_ff @(posedge clk) begin
		if (wr_buf) buf_q[fill_q] <= cmd.absorb ? in_byte : pad_val;
		if (cmd.load) begin
			for (int i = 0; i < BLOCK_BYTES; i++) begin
				work_q[i]      <= chain_q[i];
				work_q[i + 16] <= cmd.final_blk ? csum_q[i] : buf_q[i];
				work_q[i + 32] <= chain_q[i] ^ (cmd.final_blk ? csum_q[i] : buf_q[i]);
			end
		end
		if (cmd.round_step) begin
			for (int i = 0; i < WORK_BYTES - 1; i++) work_q[i] <= work_q[i + 1];
			work_q[WORK_BYTES-1] <= step_val;
		end
	end

	always_comb begin
		for (int i = 0; i < BLOCK_BYTES; i++) digest[127 - 8*i -: 8] = chain_q[i];
	end

endmodule

[hw/rtl/md2_hash_engine_core.sv]
// Sequence: each full 16-byte block is loaded, then run through the S-box
// steps and the checksum steps; the end item starts padding (a whole pad
// block when it also completes a block); the checksum block comes last.
// Throughput: one byte per cycle into the buffer while idle, then one S-box
// step per cycle in the shared work-block unit; no byte is taken meanwhile.
// Reset: arst_n clears chaining state, checksum, fill count and the controller.
// ----------------------------------------------------------------------------
// MD2 hash engine core
// Streams message bytes and returns the 128-bit MD2 digest at end of message.
// ----------------------------------------------------------------------------
`include "md2_hash_engine_core_assert.svh"

module md2_hash_engine_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [md2_pkg::TDATA_IN_W-1:0]     s_tdata,  // data_byte
	input  logic [md2_pkg::TUSER_IN_W-1:0]     s_tuser,  // byte_present
	input  logic                               s_tlast,  // end_of_message
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [md2_pkg::TDATA_OUT_W-1:0]    m_tdata   // digest_low, digest_high
);
	import md2_pkg::*;

	md2_cmd_t     cmd;
	md2_stat_t    stat;
	logic [127:0] digest;
	logic         in_fire;
	logic [4:0]   cmd_vec;

	assign in_fire = s_tvalid && s_tready;
	assign cmd_vec = {cmd.absorb, cmd.pad_byte, cmd.load, cmd.round_step, cmd.csum_step};

	md2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_present(s_tuser[0]),
		.in_end    (s_tlast),
		.out_taken (m_tvalid && m_tready),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (s_tready),
		.out_valid (m_tvalid)
	);

	md2_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.in_byte(s_tdata),
		.stat   (stat),
		.digest (digest)
	);

	assign m_tdata = {digest[63:0], digest[127:64]};

	`MD2_ASSERT_IMP(a_no_take_while_out, m_tvalid, !s_tready)
	`MD2_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd_vec))
	`MD2_ASSERT_NXT(a_clear_idle, m_tvalid && m_tready, s_tready && !m_tvalid)

endmodule
